@@ hw/rtl/snkt_pkg.sv @@
package snkt_pkg;

    // field widths fixed by the stream format
    localparam int OPCODE_W = 3;
    localparam int IN_KEY_W = 32;
    localparam int PAGE_W   = 31;
    localparam int SLOT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OUT_IDX_W = 7;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ROUTE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // compare results latched in each cell
    typedef struct packed {
        logic ge;
        logic gt;
        logic eq;
        logic peq;
    } snkt_flags_t;

    // per-cell load selects for a row update
    typedef struct packed {
        logic load_new;
        logic load_left;
        logic load_right;
    } snkt_ctl_t;

endpackage

@@ hw/rtl/snkt_first.sv @@
module snkt_first import snkt_pkg::*; #(
    parameter int N = 64
) (
    input  logic [N-1:0] req,
    output logic [N-1:0] first,
    output logic [N-1:0] upto,
    output logic         found
);

    logic [N-1:0] req_m1;

    assign req_m1 = req - {{(N-1){1'b0}}, 1'b1};
    // lowest set bit
    assign first  = req & ~req_m1;
    // set from the lowest set bit upward
    assign upto   = ~(req_m1 & ~req);
    assign found  = |req;

endmodule

@@ hw/rtl/snkt_cell.sv @@
module snkt_cell import snkt_pkg::*; #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 cmp_en,
    input  logic                 key_signed,
    input  logic [KEY_WIDTH-1:0] target_rank,
    input  logic [PAGE_W-1:0]    target_page,
    output snkt_flags_t          flags,
    input  snkt_ctl_t            ctl,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic [PAGE_W-1:0]    new_page,
    input  logic [SLOT_W-1:0]    new_slot,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic [PAGE_W-1:0]    left_page,
    input  logic [SLOT_W-1:0]    left_slot,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic [PAGE_W-1:0]    right_page,
    input  logic [SLOT_W-1:0]    right_slot,
    output logic [KEY_WIDTH-1:0] key,
    output logic [PAGE_W-1:0]    page,
    output logic [SLOT_W-1:0]    slot
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [SLOT_W-1:0]    slot_reg;
    snkt_flags_t          flags_reg;
    logic [KEY_WIDTH-1:0] own_rank;
    snkt_flags_t          flags_next;

    // flip the sign bit when keys are signed, so signed order becomes unsigned order
    assign own_rank = key_reg ^ {key_signed, {(KEY_WIDTH-1){1'b0}}};

    always_comb
    begin
        flags_next.ge  = own_rank >= target_rank;
        flags_next.gt  = own_rank > target_rank;
        flags_next.eq  = own_rank == target_rank;
        flags_next.peq = page_reg == target_page;
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            flags_reg <= flags_next;
        end
        if (ctl.load_new)
        begin
            key_reg  <= new_key;
            page_reg <= new_page;
            slot_reg <= new_slot;
        end
        else if (ctl.load_left)
        begin
            key_reg  <= left_key;
            page_reg <= left_page;
            slot_reg <= left_slot;
        end
        else if (ctl.load_right)
        begin
            key_reg  <= right_key;
            page_reg <= right_page;
            slot_reg <= right_slot;
        end
    end

    assign flags = flags_reg;
    assign key   = key_reg;
    assign page  = page_reg;
    assign slot  = slot_reg;

endmodule

@@ hw/rtl/sorted_node_key_table.sv @@
// channel   | dir | signals                          | content
// ----------+-----+----------------------------------+----------------------------------
// s_axis    | in  | s_tvalid s_tready s_tdata[87:0]  | opcode, search_key, rid_page,
//           |     |                                  | rid_slot
// m_axis    | out | m_tvalid m_tready m_tdata[63:0]  | status, result_page, result_slot,
//           |     |                                  | result_index, entry_count
// cfg       | in  | cfg_valid cfg_ready cfg_data[0]  | key_signed
//
// for each item, the accept edge latches compare flags in every cell; the resolve
// state then picks positions from the flags and shifts the cell row in place
// a new item is taken only when the previous one has been resolved
// the resolve cycle waits while the output register holds an untaken result
// reset clears the entry count, the control state and sets key_signed; entry
// contents need no clearing since only entries below the count are ever used
module sorted_node_key_table import snkt_pkg::*; #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[2:0], search_key[34:3], rid_page[65:35], rid_slot[81:66], zero[87:82]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[1:0], result_page[32:2], result_slot[48:33], result_index[55:49],
    // entry_count[62:56], zero[63]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (KEY_WIDTH > IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;

    localparam logic S_IDLE    = 1'b0;
    localparam logic S_RESOLVE = 1'b1;

    logic                  state_reg, state_next;
    logic                  key_signed_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [KEY_WIDTH-1:0]  key_reg;
    logic [PAGE_W-1:0]     page_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // input unpacking
    logic [OPCODE_W-1:0]   in_op;
    logic [IN_KEY_W-1:0]   in_key_raw;
    logic [EXT_W-1:0]      in_key_ext;
    logic [KEY_WIDTH-1:0]  in_key;
    logic [PAGE_W-1:0]     in_page;
    logic [SLOT_W-1:0]     in_slot;
    logic [KEY_WIDTH-1:0]  in_rank;
    logic                  accept;
    logic                  commit;

    // cell row
    snkt_flags_t           cell_flags [CAPACITY];
    snkt_ctl_t             cell_ctl   [CAPACITY];
    logic [KEY_WIDTH-1:0]  cell_key   [CAPACITY];
    logic [PAGE_W-1:0]     cell_page  [CAPACITY];
    logic [SLOT_W-1:0]     cell_slot  [CAPACITY];

    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   last_valid;
    logic [CAPACITY-1:0]   ge_vec, gt_vec, eq_vec, peq_vec;
    logic [CAPACITY-1:0]   low_first, low_upto;
    logic [CAPACITY-1:0]   up_first, up_upto;
    logic [CAPACITY-1:0]   pf_first, pf_upto;
    logic                  low_found, up_found, pf_found;
    logic [CAPACITY-1:0]   after_low, at_pos, route_sel;

    logic                  hit;
    logic                  insert_do, remove_do;
    logic [CNT_W-1:0]      low_pos, route_pos, pf_pos;
    logic [PAGE_W-1:0]     hit_page, route_page;
    logic [SLOT_W-1:0]     hit_slot;

    logic [STATUS_W-1:0]   res_status;
    logic [PAGE_W-1:0]     res_page;
    logic [SLOT_W-1:0]     res_slot;
    logic [CNT_W-1:0]      res_index;

    // index of the set bit of a one-hot vector, zero when none is set
    function automatic logic [CNT_W-1:0] onehot_idx(input logic [CAPACITY-1:0] v);
        logic [CNT_W-1:0] r;
        r = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (v[i])
            begin
                r = r | CNT_W'(i);
            end
        end
        return r;
    endfunction

    assign in_op      = s_tdata[2:0];
    assign in_key_raw = s_tdata[34:3];
    assign in_page    = s_tdata[65:35];
    assign in_slot    = s_tdata[81:66];
    // only the low KEY_WIDTH bits of the key field count
    assign in_key_ext = EXT_W'(in_key_raw);
    assign in_key     = in_key_ext[KEY_WIDTH-1:0];
    assign in_rank    = in_key ^ {key_signed_reg, {(KEY_WIDTH-1){1'b0}}};

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign commit    = (state_reg == S_RESOLVE) && (!m_valid_reg || m_tready);

    // occupancy and flag vectors
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_vec[i] = CNT_W'(i) < count_reg;
            ge_vec[i]    = cell_flags[i].ge;
            gt_vec[i]    = cell_flags[i].gt;
            eq_vec[i]    = cell_flags[i].eq;
            peq_vec[i]   = cell_flags[i].peq;
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            last_valid[i] = valid_vec[i] && !valid_vec[i+1];
        end
        last_valid[CAPACITY-1] = valid_vec[CAPACITY-1];
    end

    // lower position: first held entry with key >= search key
    snkt_first #(.N(CAPACITY)) u_low (
        .req   (ge_vec & valid_vec),
        .first (low_first),
        .upto  (low_upto),
        .found (low_found)
    );

    // upper position: first held entry past the sentinel with key > search key
    snkt_first #(.N(CAPACITY)) u_up (
        .req   (gt_vec & valid_vec & ~{{(CAPACITY-1){1'b0}}, 1'b1}),
        .first (up_first),
        .upto  (up_upto),
        .found (up_found)
    );

    // first held entry whose page matches
    snkt_first #(.N(CAPACITY)) u_pf (
        .req   (peq_vec & valid_vec),
        .first (pf_first),
        .upto  (pf_upto),
        .found (pf_found)
    );

    assign low_pos = low_found ? onehot_idx(low_first) : count_reg;
    assign pf_pos  = pf_found ? onehot_idx(pf_first) : count_reg;
    assign hit     = |(low_first & eq_vec);

    always_comb
    begin
        // route picks the entry just before the upper position, or the last one
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            route_sel[i] = up_first[i+1] || (!up_found && last_valid[i]);
        end
        route_sel[CAPACITY-1] = !up_found && last_valid[CAPACITY-1];
        route_pos = onehot_idx(route_sel);

        hit_page   = '0;
        hit_slot   = '0;
        route_page = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (low_first[i])
            begin
                hit_page = hit_page | cell_page[i];
                hit_slot = hit_slot | cell_slot[i];
            end
            if (route_sel[i])
            begin
                route_page = route_page | cell_page[i];
            end
        end
    end

    // shift control for the cell row
    assign insert_do = commit && (op_reg == OP_INSERT) && !hit &&
                       (count_reg < CNT_W'(CAPACITY));
    assign remove_do = commit && (op_reg == OP_REMOVE) && hit;
    // cells at or past the lower position; at or past the count when there is no lower position
    assign after_low = low_upto | ~valid_vec;
    assign at_pos    = after_low & ~{after_low[CAPACITY-2:0], 1'b0};

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctl[i].load_new   = insert_do && at_pos[i];
            cell_ctl[i].load_left  = insert_do && after_low[i] && !at_pos[i];
            cell_ctl[i].load_right = remove_do && after_low[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_WIDTH-1:0] l_key, r_key;
            logic [PAGE_W-1:0]    l_page, r_page;
            logic [SLOT_W-1:0]    l_slot, r_slot;

            if (g == 0)
            begin : g_head
                assign l_key  = key_reg;
                assign l_page = page_reg;
                assign l_slot = slot_reg;
            end
            else
            begin : g_mid_l
                assign l_key  = cell_key[g-1];
                assign l_page = cell_page[g-1];
                assign l_slot = cell_slot[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign r_key  = cell_key[g];
                assign r_page = cell_page[g];
                assign r_slot = cell_slot[g];
            end
            else
            begin : g_mid_r
                assign r_key  = cell_key[g+1];
                assign r_page = cell_page[g+1];
                assign r_slot = cell_slot[g+1];
            end

            snkt_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
                .clk         (clk),
                .cmp_en      (accept),
                .key_signed  (key_signed_reg),
                .target_rank (in_rank),
                .target_page (in_page),
                .flags       (cell_flags[g]),
                .ctl         (cell_ctl[g]),
                .new_key     (key_reg),
                .new_page    (page_reg),
                .new_slot    (slot_reg),
                .left_key    (l_key),
                .left_page   (l_page),
                .left_slot   (l_slot),
                .right_key   (r_key),
                .right_page  (r_page),
                .right_slot  (r_slot),
                .key         (cell_key[g]),
                .page        (cell_page[g]),
                .slot        (cell_slot[g])
            );
        end
    endgenerate

    // result of the item under resolution
    always_comb
    begin
        res_status = ST_ABSENT;
        res_page   = '0;
        res_slot   = '0;
        res_index  = '0;
        count_next = count_reg;
        case (op_reg)
            OP_LOOKUP:
            begin
                res_index = low_pos;
                if (hit)
                begin
                    res_status = ST_DONE;
                    res_page   = hit_page;
                    res_slot   = hit_slot;
                end
            end
            OP_ROUTE:
            begin
                if (count_reg != '0)
                begin
                    res_status = ST_DONE;
                    res_page   = route_page;
                    res_index  = route_pos;
                end
            end
            OP_INSERT:
            begin
                res_index = low_pos;
                if (hit)
                begin
                    res_status = ST_DUP;
                end
                else if (count_reg >= CNT_W'(CAPACITY))
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_status = ST_DONE;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                res_index = low_pos;
                if (hit)
                begin
                    res_status = ST_DONE;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_FIND:
            begin
                res_index = pf_pos;
                if (pf_found)
                begin
                    res_status = ST_DONE;
                    res_page   = page_reg;
                end
            end
            default:
            begin
                res_status = ST_ABSENT;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_signed_reg <= 1'b1;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                key_signed_reg <= cfg_data;
            end
        end
    end

    // item payload and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            key_reg  <= in_key;
            page_reg <= in_page;
            slot_reg <= in_slot;
        end
        if (commit)
        begin
            m_data_reg <= {1'b0, OUT_IDX_W'(count_next), OUT_IDX_W'(res_index),
                           res_slot, res_page, res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
